// File: rtl/pba_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_pkg
// Shared constants of the page bitmap allocator: defaults, field widths,
// opcodes and status codes.
// ----------------------------------------------------------------------------
package pba_pkg;

  localparam int unsigned NUM_PAGES_DEF  = 1024;
  localparam int unsigned BOOT_PAGES_DEF = 64;

  localparam int unsigned START_W  = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned FIRST_W  = 10;
  localparam int unsigned FREE_W   = 11;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ZERO_CNT = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_FEW  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NO_RUN   = 2'd3;

endpackage

// File: rtl/pba_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_req_if
// Request channel: allocate or free a range of pages.
// ----------------------------------------------------------------------------
interface pba_req_if;
  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic [pba_pkg::START_W-1:0]   start_page;
  logic [pba_pkg::COUNT_W-1:0]   page_count;

  modport source (output valid, output opcode, output start_page, output page_count,
                  input ready);
  modport sink   (input valid, input opcode, input start_page, input page_count,
                  output ready);
endinterface

// File: rtl/pba_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_rsp_if
// Response channel: status, granted start page and free page count.
// ----------------------------------------------------------------------------
interface pba_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [pba_pkg::STATUS_W-1:0]  status;
  logic [pba_pkg::FIRST_W-1:0]   first_page;
  logic [pba_pkg::FREE_W-1:0]    pages_free;

  modport source (output valid, output status, output first_page, output pages_free,
                  input ready);
  modport sink   (input valid, input status, input first_page, input pages_free,
                  output ready);
endinterface

// File: rtl/page_bitmap_allocator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// First-fit contiguous page allocator over a one-bit-per-page map held in a
// 32-bit wide synchronous RAM, with a running free page count.
//
//   channel | dir | payload                              | accepted when
//   --------+-----+--------------------------------------+-----------------
//   req_i   | in  | opcode, start_page, page_count       | valid && ready
//   rsp_o   | out | status, first_page, pages_free       | valid && ready
//
// One request at a time. Rejects pass from S_CHECK through S_DONE to the
// response register. Allocate: S_CHECK, then a scan of up to MAP_WORDS map
// words (one map word per cycle through the RAM read port), then a read and
// a write back per map word touched by the granted run. Free: a read, then a
// modify and write back, per map word touched. After reset a sweep writes the
// initial map while ready is low. A waiting response does not block the next
// request; only its completion waits for the response register to empty.
// ----------------------------------------------------------------------------
module page_bitmap_allocator #(
  parameter int unsigned NUM_PAGES  = pba_pkg::NUM_PAGES_DEF,
  parameter int unsigned BOOT_PAGES = pba_pkg::BOOT_PAGES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  pba_req_if.sink    req_i,
  pba_rsp_if.source  rsp_o
);

  localparam int unsigned MAP_WORDS = (NUM_PAGES + 31) / 32;
  localparam int unsigned WW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned EW        = (WW + 6 > 12) ? WW + 6 : 12;
  localparam int unsigned FW        = $clog2(NUM_PAGES + 1);
  localparam int unsigned CW        = (FW > pba_pkg::COUNT_W) ? FW : pba_pkg::COUNT_W;
  localparam int unsigned RES_PAGES = (BOOT_PAGES < NUM_PAGES) ? BOOT_PAGES
                                                               : NUM_PAGES;

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_WR    = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  // lowest set bit
  function automatic logic [4:0] lsb_idx(input logic [31:0] v);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 31; i >= 0; i--) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  // highest set bit
  function automatic logic [4:0] msb_idx(input logic [31:0] v);
    logic [4:0] idx;
    idx = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) idx = 5'(i);
    end
    return idx;
  endfunction

  function automatic logic [5:0] popcnt32(input logic [31:0] v);
    logic [5:0] n;
    n = 6'd0;
    for (int i = 0; i < 32; i++) begin
      n = n + 6'(v[i]);
    end
    return n;
  endfunction

  // low n bits set, n in 0..32
  function automatic logic [31:0] below32(input logic [5:0] n);
    logic [31:0] m;
    if (n[5]) m = '1;
    else      m = (32'd1 << n[4:0]) - 32'd1;
    return m;
  endfunction

  // bits of map word w whose page index is below lim
  function automatic logic [31:0] word_below(input logic [WW-1:0] w, input logic [EW-1:0] lim);
    logic [EW-1:0] base;
    logic [31:0]   m;
    base = EW'({w, 5'b0});
    if (lim >= base + EW'(32)) m = '1;
    else if (lim <= base)      m = '0;
    else                       m = below32(6'(lim - base));
    return m;
  endfunction

  // map RAM
  logic [31:0]   map_mem [MAP_WORDS];
  logic          mem_re;
  logic [WW-1:0] mem_raddr;
  logic          mem_we;
  logic [WW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;
  logic [31:0]   rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= map_mem[mem_raddr];
  end

  // control
  logic [2:0]    state_q, state_d;
  logic [WW-1:0] init_cnt_q, init_cnt_d;
  logic [FW-1:0] free_q, free_d;
  logic          rsp_valid_q, rsp_valid_d;

  // request and working registers
  logic                          op_q, op_d;
  logic [pba_pkg::START_W-1:0]   start_q, start_d;
  logic [pba_pkg::COUNT_W-1:0]   count_q, count_d;
  logic [WW-1:0]                 word_q, word_d;
  logic [pba_pkg::COUNT_W-1:0]   runlen_q, runlen_d;
  logic [EW-1:0]                 seg_start_q, seg_start_d;
  logic [EW-1:0]                 lo_q, lo_d;
  logic [EW-1:0]                 hi_q, hi_d;
  logic [pba_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [EW-1:0]                 first_q, first_d;
  logic [pba_pkg::STATUS_W-1:0]  rsp_status_q, rsp_status_d;
  logic [pba_pkg::FIRST_W-1:0]   rsp_first_q, rsp_first_d;
  logic [pba_pkg::FREE_W-1:0]    rsp_free_q, rsp_free_d;

  // scan datapath
  logic [EW-1:0] base;
  logic [31:0]   free_bits, used_bits;
  logic          all_free;
  logic [5:0]    lead, top;
  logic          cont_hit;
  logic [EW-1:0] cont_start;
  logic [31:0]   lvl [6];
  logic [31:0]   fit;
  logic          inner_hit;
  logic [EW-1:0] inner_start;
  logic          scan_hit;
  logic [EW-1:0] hit_start;

  // read-modify-write datapath
  logic [4:0]    lo_cut;
  logic [EW-1:0] hi_diff;
  logic [5:0]    hi_cut;
  logic [31:0]   rmask;
  logic [WW-1:0] last_word;
  logic [5:0]    freed;
  logic [EW-1:0] free_end;

  logic req_fire;
  logic rsp_fire;

  assign req_fire = req_i.valid && req_i.ready;
  assign rsp_fire = rsp_valid_q && rsp_o.ready;

  always_comb begin
    logic [pba_pkg::COUNT_W-1:0] lowmask;
    base      = EW'({word_q, 5'b0});
    free_bits = ~rdata_q & word_below(word_q, EW'(NUM_PAGES));
    used_bits = ~free_bits;
    all_free  = &free_bits;
    lead      = all_free ? 6'd32 : {1'b0, lsb_idx(used_bits)};
    top       = all_free ? 6'd32 : 6'(5'd31 - msb_idx(used_bits));
    // run carried in from lower words, extended by the free bits at bit 0
    cont_hit   = (12'(runlen_q) + 12'(lead)) >= 12'(count_q);
    cont_start = (runlen_q == '0) ? base : seg_start_q;

    // lvl[k][i]: 2^k free pages starting at bit i inside this word
    lvl[0] = free_bits;
    for (int k = 0; k < 5; k++) begin
      lvl[k+1] = lvl[k] & (lvl[k] >> (1 << k));
    end
    fit = '1;
    for (int k = 0; k < 6; k++) begin
      lowmask = pba_pkg::COUNT_W'((1 << k) - 1);
      if (count_q[k]) fit = fit & (lvl[k] >> 6'(count_q & lowmask));
    end
    inner_hit   = (count_q <= pba_pkg::COUNT_W'(32)) && (fit != '0);
    inner_start = base + EW'(lsb_idx(fit));
    scan_hit    = cont_hit || inner_hit;
    hit_start   = cont_hit ? cont_start : inner_start;

    lo_cut    = (lo_q > base) ? 5'(lo_q - base) : 5'd0;
    hi_diff   = hi_q - base;
    hi_cut    = (hi_diff >= EW'(32)) ? 6'd32 : 6'(hi_diff);
    rmask     = (32'hFFFF_FFFF << lo_cut) & below32(hi_cut);
    last_word = WW'((hi_q - EW'(1)) >> 5);
    freed     = popcnt32(rdata_q & rmask);
  end

  assign free_end = (EW'(start_q) + EW'(count_q) < EW'(NUM_PAGES))
                  ? EW'(start_q) + EW'(count_q) : EW'(NUM_PAGES);

  always_comb begin
    state_d      = state_q;
    init_cnt_d   = init_cnt_q;
    free_d       = free_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    op_d         = op_q;
    start_d      = start_q;
    count_d      = count_q;
    word_d       = word_q;
    runlen_d     = runlen_q;
    seg_start_d  = seg_start_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    status_d     = status_q;
    first_d      = first_q;
    rsp_status_d = rsp_status_q;
    rsp_first_d  = rsp_first_q;
    rsp_free_d   = rsp_free_q;
    mem_re       = 1'b0;
    mem_raddr    = word_q;
    mem_we       = 1'b0;
    mem_waddr    = word_q;
    mem_wdata    = (op_q == pba_pkg::OP_ALLOC) ? (rdata_q | rmask) : (rdata_q & ~rmask);

    case (state_q)
      S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = init_cnt_q;
        mem_wdata = word_below(init_cnt_q, EW'(RES_PAGES));
        init_cnt_d = init_cnt_q + WW'(1);
        if (init_cnt_q == WW'(MAP_WORDS - 1)) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (req_fire) begin
          op_d    = req_i.opcode;
          start_d = req_i.start_page;
          count_d = req_i.page_count;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        status_d = pba_pkg::STATUS_OK;
        first_d  = '0;
        if (count_q == '0) begin
          status_d = pba_pkg::STATUS_ZERO_CNT;
          state_d  = S_DONE;
        end else if (op_q == pba_pkg::OP_ALLOC) begin
          if (CW'(count_q) > CW'(free_q)) begin
            status_d = pba_pkg::STATUS_TOO_FEW;
            state_d  = S_DONE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = '0;
            word_d    = '0;
            runlen_d  = '0;
            state_d   = S_SCAN;
          end
        end else if (EW'(start_q) >= EW'(NUM_PAGES)) begin
          state_d = S_DONE;
        end else begin
          lo_d    = EW'(start_q);
          hi_d    = free_end;
          word_d  = WW'(EW'(start_q) >> 5);
          state_d = S_RD;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          lo_d    = hit_start;
          hi_d    = hit_start + EW'(count_q);
          word_d  = WW'(hit_start >> 5);
          first_d = hit_start;
          free_d  = free_q - FW'(count_q);
          state_d = S_RD;
        end else if (word_q == WW'(MAP_WORDS - 1)) begin
          status_d = pba_pkg::STATUS_NO_RUN;
          state_d  = S_DONE;
        end else begin
          if (all_free) begin
            runlen_d    = runlen_q + pba_pkg::COUNT_W'(32);
            seg_start_d = cont_start;
          end else begin
            runlen_d    = pba_pkg::COUNT_W'(top);
            seg_start_d = base + EW'(6'd32 - top);
          end
          mem_re    = 1'b1;
          mem_raddr = word_q + WW'(1);
          word_d    = word_q + WW'(1);
        end
      end
      S_RD: begin
        mem_re  = 1'b1;
        state_d = S_WR;
      end
      S_WR: begin
        mem_we = 1'b1;
        // only pages that were in use raise the count
        if (op_q == pba_pkg::OP_FREE) free_d = free_q + FW'(freed);
        if (word_q == last_word) begin
          state_d = S_DONE;
        end else begin
          word_d  = word_q + WW'(1);
          state_d = S_RD;
        end
      end
      S_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_first_d  = pba_pkg::FIRST_W'(first_q);
          rsp_free_d   = pba_pkg::FREE_W'(free_q);
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_cnt_q  <= '0;
      free_q      <= FW'(NUM_PAGES - RES_PAGES);
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      init_cnt_q  <= init_cnt_d;
      free_q      <= free_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    start_q      <= start_d;
    count_q      <= count_d;
    word_q       <= word_d;
    runlen_q     <= runlen_d;
    seg_start_q  <= seg_start_d;
    lo_q         <= lo_d;
    hi_q         <= hi_d;
    status_q     <= status_d;
    first_q      <= first_d;
    rsp_status_q <= rsp_status_d;
    rsp_first_q  <= rsp_first_d;
    rsp_free_q   <= rsp_free_d;
  end

  assign req_i.ready      = (state_q == S_IDLE);
  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = rsp_status_q;
  assign rsp_o.first_page = rsp_first_q;
  assign rsp_o.pages_free = rsp_free_q;

endmodule

// File: rtl/pba_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pba_checker
// Port-level checks of the page bitmap allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pba_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [pba_pkg::STATUS_W-1:0]  rsp_status_i,
  input logic [pba_pkg::FIRST_W-1:0]   rsp_first_i,
  input logic [pba_pkg::FREE_W-1:0]    rsp_free_i
);

  // one request in flight: busy right after a request is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i) |=> !req_ready_i)
    else $error("request taken while previous one still in progress");

  // a rejected request carries no start page
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && (rsp_status_i != pba_pkg::STATUS_OK)) |-> (rsp_first_i == '0))
    else $error("nonzero first page on a rejected request");

  // stalled response holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_i && !rsp_ready_i) |=>
      (rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_first_i) && $stable(rsp_free_i)))
    else $error("response changed while stalled");

endmodule

bind page_bitmap_allocator pba_checker u_pba_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_first_i  (rsp_o.first_page),
  .rsp_free_i   (rsp_o.pages_free)
);

// File: dv/page_bitmap_allocator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_bitmap_allocator_tb
// Self-checking bench for the page allocator. A directed table covers the
// rejects, the map boundaries, double frees and a fragmented map. It is
// followed by random allocate/free traffic. Every response is checked field
// by field against the table or a local copy of the page map, with random
// idling on both channels and one long response back-pressure stretch.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_tb;

  localparam int TOTAL     = pba_pkg::NUM_PAGES_DEF;
  localparam int KERNEL    = pba_pkg::BOOT_PAGES_DEF;
  localparam int MAP_WORDS = (TOTAL + 31) / 32;
  localparam int RESERVED  = (KERNEL < TOTAL) ? KERNEL : TOTAL;
  localparam int N_RANDOM  = 1900;

  typedef struct packed {
    logic [pba_pkg::STATUS_W-1:0] status;
    logic [pba_pkg::FIRST_W-1:0]  first;
    logic [pba_pkg::FREE_W-1:0]   free;
  } rsp_t;

  typedef struct {
    logic                        op;
    logic [pba_pkg::START_W-1:0] sp;
    logic [pba_pkg::COUNT_W-1:0] pc;
    bit                          typed;
    rsp_t                        want;
  } dir_row_t;

  typedef struct {
    int base;
    int len;
  } run_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pba_req_if req_if ();
  pba_rsp_if rsp_if ();

  page_bitmap_allocator #(
    .NUM_PAGES  (TOTAL),
    .BOOT_PAGES (KERNEL)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // local page map and free count
  logic [31:0]                page_map [MAP_WORDS];
  logic [pba_pkg::FREE_W-1:0] free_cnt;

  rsp_t     rsp_due_q [$];
  run_t     granted_runs_q [$];
  dir_row_t dir_tbl [$];

  int   err_cnt = 0;
  int   rsp_seen = 0;
  int   cyc = 0;
  rsp_t want;

  always @(posedge clk_i) cyc <= cyc + 1;

  // both sides run without idling inside this window
  function automatic bit idle_allowed();
    return !(cyc >= 2000 && cyc < 12000);
  endfunction

  function automatic dir_row_t row(input logic op, input int sp, input int pc, input bit typed,
                                   input logic [pba_pkg::STATUS_W-1:0] st, input int fp,
                                   input int fr);
    dir_row_t r;
    r.op          = op;
    r.sp          = pba_pkg::START_W'(sp);
    r.pc          = pba_pkg::COUNT_W'(pc);
    r.typed       = typed;
    r.want.status = st;
    r.want.first  = pba_pkg::FIRST_W'(fp);
    r.want.free   = pba_pkg::FREE_W'(fr);
    return r;
  endfunction

  task automatic page_map_update(input logic op, input logic [pba_pkg::START_W-1:0] sp,
                                 input logic [pba_pkg::COUNT_W-1:0] pc, output rsp_t r);
    int p;
    int seg_start;
    int run_len;
    int stop;
    bit found;
    run_t run;
    r         = '0;
    seg_start = 0;
    run_len   = 0;
    found     = 1'b0;
    if (pc == 0) begin
      r.status = pba_pkg::STATUS_ZERO_CNT;
    end else if (op == pba_pkg::OP_ALLOC) begin
      if (pc > free_cnt) begin
        r.status = pba_pkg::STATUS_TOO_FEW;
      end else begin
        for (p = 0; p < TOTAL && !found; p++) begin
          if (!page_map[p / 32][p % 32]) begin
            if (run_len == 0) seg_start = p;
            run_len++;
            if (run_len >= int'(pc)) found = 1'b1;
          end else begin
            run_len = 0;
          end
        end
        if (found) begin
          for (p = seg_start; p < seg_start + int'(pc); p++) page_map[p / 32][p % 32] = 1'b1;
          free_cnt = free_cnt - pc;
          r.first  = pba_pkg::FIRST_W'(seg_start);
          run.base = seg_start;
          run.len  = int'(pc);
          granted_runs_q.push_back(run);
        end else begin
          r.status = pba_pkg::STATUS_NO_RUN;
        end
      end
    end else begin
      // clipped at the end of the map; only used pages raise the count
      stop = int'(sp) + int'(pc);
      if (stop > TOTAL) stop = TOTAL;
      for (p = int'(sp); p < stop; p++) begin
        if (page_map[p / 32][p % 32]) begin
          page_map[p / 32][p % 32] = 1'b0;
          free_cnt = free_cnt + 1'b1;
        end
      end
    end
    r.free = free_cnt;
  endtask

  task automatic send_req(input logic op, input logic [pba_pkg::START_W-1:0] sp,
                          input logic [pba_pkg::COUNT_W-1:0] pc, input bit typed,
                          input rsp_t typed_rsp);
    rsp_t got;
    @(negedge clk_i);
    while (idle_allowed() && $urandom_range(0, 99) < 8) begin
      req_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.opcode     <= op;
    req_if.start_page <= sp;
    req_if.page_count <= pc;
    do @(posedge clk_i); while (!req_if.ready);
    page_map_update(op, sp, pc, got);
    rsp_due_q.push_back(typed ? typed_rsp : got);
  endtask

  task automatic gen_random_req(output logic op, output logic [pba_pkg::START_W-1:0] sp,
                                output logic [pba_pkg::COUNT_W-1:0] pc);
    int sel;
    int idx;
    int lo;
    run_t run;
    sel = $urandom_range(0, 99);
    if (sel < 45 || (sel < 80 && granted_runs_q.size() == 0)) begin
      op  = pba_pkg::OP_ALLOC;
      sp  = pba_pkg::START_W'($urandom);
      sel = $urandom_range(0, 99);
      if (sel < 70)      pc = pba_pkg::COUNT_W'($urandom_range(1, 16));
      else if (sel < 90) pc = pba_pkg::COUNT_W'($urandom_range(17, 128));
      else if (sel < 98) pc = pba_pkg::COUNT_W'($urandom_range(129, 1024));
      else               pc = pba_pkg::COUNT_W'($urandom_range(1025, 2047));
    end else if (sel < 80) begin
      // release something that was granted, whole or in part
      idx = $urandom_range(0, granted_runs_q.size() - 1);
      run = granted_runs_q[idx];
      granted_runs_q.delete(idx);
      op = pba_pkg::OP_FREE;
      if ($urandom_range(0, 99) < 80) begin
        sp = pba_pkg::START_W'(run.base);
        pc = pba_pkg::COUNT_W'(run.len);
      end else begin
        lo = run.base + $urandom_range(0, run.len - 1);
        sp = pba_pkg::START_W'(lo);
        pc = pba_pkg::COUNT_W'($urandom_range(1, run.base + run.len - lo));
      end
    end else if (sel < 90) begin
      op = pba_pkg::OP_FREE;
      sp = pba_pkg::START_W'($urandom_range(0, TOTAL - 1));
      pc = pba_pkg::COUNT_W'($urandom_range(1, 64));
    end else if (sel < 91) begin
      op = pba_pkg::OP_FREE;
      sp = '0;
      pc = pba_pkg::COUNT_W'(TOTAL);
      granted_runs_q.delete();
    end else begin
      op = 1'($urandom_range(0, 1));
      sp = pba_pkg::START_W'($urandom);
      pc = pba_pkg::COUNT_W'($urandom);
    end
  endtask

  // response sink: random idling plus one long hold-off
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
        rsp_if.ready <= 1'b0;
      end else if (!hold_done && rsp_seen >= 300) begin
        hold_done = 1'b1;
        hold_left = 600;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= !(idle_allowed() && $urandom_range(0, 99) < 8);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      rsp_seen <= rsp_seen + 1;
      if (rsp_due_q.size() == 0) begin
        err_cnt++;
        $display("%0t: response expected none, actual status %0d first_page %0d pages_free %0d",
                 $time, rsp_if.status, rsp_if.first_page, rsp_if.pages_free);
      end else begin
        want = rsp_due_q.pop_front();
        if (rsp_if.status !== want.status) begin
          err_cnt++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, rsp_if.status);
        end
        if (rsp_if.first_page !== want.first) begin
          err_cnt++;
          $display("%0t: first_page expected %0d actual %0d",
                   $time, want.first, rsp_if.first_page);
        end
        if (rsp_if.pages_free !== want.free) begin
          err_cnt++;
          $display("%0t: pages_free expected %0d actual %0d",
                   $time, want.free, rsp_if.pages_free);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic                        op;
    logic [pba_pkg::START_W-1:0] sp;
    logic [pba_pkg::COUNT_W-1:0] pc;
    req_if.valid      = 1'b0;
    req_if.opcode     = pba_pkg::OP_ALLOC;
    req_if.start_page = '0;
    req_if.page_count = '0;

    for (int w = 0; w < MAP_WORDS; w++) page_map[w] = '0;
    for (int p = 0; p < RESERVED; p++) page_map[p / 32][p % 32] = 1'b1;
    free_cnt = pba_pkg::FREE_W'(TOTAL - RESERVED);

    // rejects, boundaries, double free, clipping, fragmented map
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0,    0, 1'b1,
                          pba_pkg::STATUS_ZERO_CNT,    0,  960));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,     5,    0, 1'b1,
                          pba_pkg::STATUS_ZERO_CNT,    0,  960));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0, 2047, 1'b1,
                          pba_pkg::STATUS_TOO_FEW,     0,  960));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0, 1024, 1'b1,
                          pba_pkg::STATUS_TOO_FEW,     0,  960));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0,  961, 1'b1,
                          pba_pkg::STATUS_TOO_FEW,     0,  960));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0,    1, 1'b1,
                          pba_pkg::STATUS_OK,         64,  959));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC, 1023,   31, 1'b1,
                          pba_pkg::STATUS_OK,         65,  928));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,    64,    1, 1'b1,
                          pba_pkg::STATUS_OK,          0,  929));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,    64,    1, 1'b1,
                          pba_pkg::STATUS_OK,          0,  929));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0,    2, 1'b1,
                          pba_pkg::STATUS_OK,         96,  927));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,  1023, 2047, 1'b1,
                          pba_pkg::STATUS_OK,          0,  927));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,     0, 2047, 1'b1,
                          pba_pkg::STATUS_OK,          0, 1024));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0, 1024, 1'b1,
                          pba_pkg::STATUS_OK,          0,    0));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0,    1, 1'b1,
                          pba_pkg::STATUS_TOO_FEW,     0,    0));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,  1023,    1, 1'b1,
                          pba_pkg::STATUS_OK,          0,    1));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0,    1, 1'b1,
                          pba_pkg::STATUS_OK,       1023,    0));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,     0, 1024, 1'b1,
                          pba_pkg::STATUS_OK,          0, 1024));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0,  512, 1'b1,
                          pba_pkg::STATUS_OK,          0,  512));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,   256,    1, 1'b1,
                          pba_pkg::STATUS_OK,          0,  513));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0,  513, 1'b1,
                          pba_pkg::STATUS_NO_RUN,      0,  513));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,   512,  512, 1'b1,
                          pba_pkg::STATUS_OK,          0,  513));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,    0,  300, 1'b1,
                          pba_pkg::STATUS_OK,        512,  213));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,   700,   40, 1'b0,
                          pba_pkg::STATUS_OK,          0,    0));
    dir_tbl.push_back(row(pba_pkg::OP_ALLOC,  682,    1, 1'b0,
                          pba_pkg::STATUS_OK,          0,    0));
    dir_tbl.push_back(row(pba_pkg::OP_FREE,     0, 1024, 1'b0,
                          pba_pkg::STATUS_OK,          0,    0));

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tbl[i]) begin
      send_req(dir_tbl[i].op, dir_tbl[i].sp, dir_tbl[i].pc, dir_tbl[i].typed,
               dir_tbl[i].want);
    end
    // directed table leaves every page free
    granted_runs_q.delete();

    for (int n = 0; n < N_RANDOM; n++) begin
      gen_random_req(op, sp, pc);
      send_req(op, sp, pc, 1'b0, '0);
    end

    @(negedge clk_i);
    req_if.valid <= 1'b0;

    while (rsp_due_q.size() != 0) @(posedge clk_i);
    repeat (150) @(posedge clk_i);

    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/pba_pkg.sv
rtl/pba_req_if.sv
rtl/pba_rsp_if.sv
rtl/page_bitmap_allocator.sv
rtl/pba_checker.sv
dv/page_bitmap_allocator_tb.sv
